>>> hdl/sbfc_pkg.sv
// Shared types and constants for the seven-byte frame checker.
package sbfc_pkg;

   // Width of the wrapping good-frame counter.
   localparam int unsigned COUNT_WIDTH = 16;

   // Frame delimiter bytes.
   localparam logic [7:0] HDR_BYTE = 8'hAA;
   localparam logic [7:0] TRL_BYTE = 8'hFF;

   // Position within a frame, one-hot.
   typedef enum logic [6:0] {
      POS_HUNT = 7'b0000001,
      POS_HDR2 = 7'b0000010,
      POS_TAB  = 7'b0000100,
      POS_DATA = 7'b0001000,
      POS_SUM  = 7'b0010000,
      POS_TRL1 = 7'b0100000,
      POS_TRL2 = 7'b1000000
   } pos_type;

   // Frame status codes.
   typedef enum logic [1:0] {
      STATUS_GOOD        = 2'd0,
      STATUS_BAD_TRAILER = 2'd1,
      STATUS_BAD_SUM     = 2'd2
   } status_type;

   // One result transaction.
   typedef struct packed {
      status_type  status;
      logic [7:0]  tab;
      logic        changed;
      logic [15:0] count;
   } result_type;

endpackage

>>> hdl/sbfc_if.sv
// Handshake interfaces for the request and response channels.
interface sbfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [7:0]  frame_tab;
   logic        tab_changed;
   logic [15:0] good_count;

   modport source (output valid, output frame_status, output frame_tab,
                   output tab_changed, output good_count, input ready);
   modport sink (input valid, input frame_status, input frame_tab,
                 input tab_changed, input good_count, output ready);
endinterface

>>> hdl/sbfc_frame_core.sv
// Frame state machine, checksum check and good-frame tracking.
module sbfc_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                emit,
   output sbfc_pkg::result_type result
);

   sbfc_pkg::pos_type pos_ff, pos_in;
   logic [7:0] tab_ff, tab_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] sum_ff, sum_in;
   logic       trl_ok_ff, trl_ok_in;
   logic [7:0] last_tab_ff, last_tab_in;
   logic       last_valid_ff, last_valid_in;
   logic [sbfc_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0] expected_sum;

   assign expected_sum = tab_ff + data_ff;

   // Next state and the result of the byte at hand.
   always_comb begin
      pos_in        = pos_ff;
      tab_in        = tab_ff;
      data_in       = data_ff;
      sum_in        = sum_ff;
      trl_ok_in     = trl_ok_ff;
      last_tab_in   = last_tab_ff;
      last_valid_in = last_valid_ff;
      count_in      = count_ff;
      emit          = 1'b0;
      result.status  = sbfc_pkg::STATUS_GOOD;
      result.tab     = tab_ff;
      result.changed = 1'b0;
      result.count   = 16'(count_ff);
      unique case (pos_ff)
         sbfc_pkg::POS_HUNT: begin
            pos_in = (rx_byte == sbfc_pkg::HDR_BYTE) ? sbfc_pkg::POS_HDR2
                                                      : sbfc_pkg::POS_HUNT;
         end
         sbfc_pkg::POS_HDR2: begin
            pos_in = (rx_byte == sbfc_pkg::HDR_BYTE) ? sbfc_pkg::POS_TAB
                                                      : sbfc_pkg::POS_HUNT;
         end
         sbfc_pkg::POS_TAB: begin
            tab_in = rx_byte;
            pos_in = sbfc_pkg::POS_DATA;
         end
         sbfc_pkg::POS_DATA: begin
            data_in = rx_byte;
            pos_in  = sbfc_pkg::POS_SUM;
         end
         sbfc_pkg::POS_SUM: begin
            sum_in = rx_byte;
            pos_in = sbfc_pkg::POS_TRL1;
         end
         sbfc_pkg::POS_TRL1: begin
            trl_ok_in = (rx_byte == sbfc_pkg::TRL_BYTE);
            pos_in    = sbfc_pkg::POS_TRL2;
         end
         sbfc_pkg::POS_TRL2: begin
            // The frame ends here: the trailer is judged before the checksum.
            emit   = 1'b1;
            pos_in = sbfc_pkg::POS_HUNT;
            if (!trl_ok_ff || rx_byte != sbfc_pkg::TRL_BYTE) begin
               result.status = sbfc_pkg::STATUS_BAD_TRAILER;
            end else if (sum_ff != expected_sum) begin
               result.status = sbfc_pkg::STATUS_BAD_SUM;
            end else begin
               count_in       = count_ff + 1'b1;
               result.count   = 16'(count_in);
               result.changed = !last_valid_ff || (last_tab_ff != tab_ff);
               last_tab_in    = tab_ff;
               last_valid_in  = 1'b1;
            end
         end
         default: begin
            pos_in = sbfc_pkg::POS_HUNT;
         end
      endcase
   end

   // Control state, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= sbfc_pkg::POS_HUNT;
         last_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else if (step) begin
         pos_ff        <= pos_in;
         last_valid_ff <= last_valid_in;
         count_ff      <= count_in;
      end
   end

   // Held frame bytes; each is written before it is read.
   always_ff @(posedge clock) begin
      if (step) begin
         tab_ff      <= tab_in;
         data_ff     <= data_in;
         sum_ff      <= sum_in;
         trl_ok_ff   <= trl_ok_in;
         last_tab_ff <= last_tab_in;
      end
   end

endmodule

>>> hdl/seven_byte_frame_checker.sv
// Top level of the seven-byte frame checker.
// Usage: received bytes arrive one per transaction on req_if (rx_byte).
// The block hunts for the header 0xAA 0xAA, then takes tab, data and
// checksum bytes and a 0xFF 0xFF trailer. On the last trailer byte it sends
// one transaction on rsp_if with the frame status (good, bad trailer or bad
// checksum), the tab, whether a good frame's tab changed, and the wrapping
// good-frame count. Bytes that do not end a frame give no response.
// Path: a byte is captured in the input register; its response, if any, is
// then registered in the output register and stays valid there until taken.
// Throughput: one byte per cycle while no response waits unaccepted.
// Stall: while a response waits unaccepted, the next byte may still be
// captured in the input register; further bytes are held off by req_if.ready
// until the response is taken.
// Reset: synchronous and active high; the block returns to hunting, with no
// good frame seen and a zero count.
module seven_byte_frame_checker (
   input  logic          clock,
   input  logic          reset,
   sbfc_req_if.sink      req_if,
   sbfc_rsp_if.source    rsp_if
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff;
   sbfc_pkg::result_type rsp_data_ff;
   logic                 out_free;
   logic                 step;
   logic                 emit;
   sbfc_pkg::result_type result;

   // Flow control between the input and output registers.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // Frame tracking.
   sbfc_frame_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_status = rsp_data_ff.status;
   assign rsp_if.frame_tab    = rsp_data_ff.tab;
   assign rsp_if.tab_changed  = rsp_data_ff.changed;
   assign rsp_if.good_count   = rsp_data_ff.count;

endmodule
